[hdl/mmoc_pkg.sv]
// Shared widths, reset values, register indexes and interface types for the calibration block.
`timescale 1ns / 1ps

package mmoc_pkg;

  localparam int RAW_W          = 16;
  localparam int CORR_W         = RAW_W + 1;
  localparam int TRK_W          = 13;
  localparam int RANGE_W        = TRK_W + 1;
  localparam int CNT_W          = 16;
  localparam int GATE_W         = 12;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_Q_W       = GAIN_W - 1;
  localparam int DIV_DW         = RANGE_W + GAIN_FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(GAIN_Q_W + 1);
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 1'd1;

  localparam logic [CNT_W-1:0]  TARGET_RST = CNT_W'(500);
  localparam logic [GATE_W-1:0] GATE_RST   = GATE_W'(400);
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  localparam logic signed [TRK_W-1:0] MAX_RST    = -TRK_W'(100);
  localparam logic signed [TRK_W-1:0] MIN_RST    = TRK_W'(100);
  localparam logic signed [TRK_W-1:0] OFFSET_RST = -TRK_W'(1);

  localparam longint GAIN_Y_VAL = ((64'd8538 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint GAIN_Z_VAL = ((64'd9389 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic signed [GAIN_W-1:0] GAIN_Y_RST = GAIN_W'(GAIN_Y_VAL);
  localparam logic signed [GAIN_W-1:0] GAIN_Z_RST = GAIN_W'(GAIN_Z_VAL);

  typedef struct packed {
    logic               in_gate;
    logic [RANGE_W-1:0] range;
  } lane_stat_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } div_res_t;

endpackage

[hdl/mmoc_lane.sv]
// One axis lane: gate check, min/max tracking, offset, range and corrected sample.
`timescale 1ns / 1ps

module mmoc_lane
  import mmoc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [RAW_W-1:0]  raw,
  input  logic [GATE_W-1:0]        gate_limit,
  input  logic                     accept,
  input  logic                     track,
  input  logic                     complete,
  output logic signed [CORR_W-1:0] corrected,
  output logic signed [TRK_W-1:0]  offset,
  output lane_stat_t               stat
);

  logic signed [TRK_W-1:0]  max_r, min_r, offset_r;
  logic signed [TRK_W-1:0]  max_nxt, min_nxt, offset_nxt;
  logic signed [CORR_W-1:0] corr_r;
  logic [RAW_W:0]           raw_ext, mag;
  logic [RAW_W-1:0]         max_ext, min_ext;
  logic [TRK_W:0]           sum, rnd;

  assign raw_ext = {raw[RAW_W-1], raw};
  assign mag     = raw[RAW_W-1] ? (~raw_ext + 1'b1) : raw_ext;
  assign max_ext = {{(RAW_W-TRK_W){max_r[TRK_W-1]}}, max_r};
  assign min_ext = {{(RAW_W-TRK_W){min_r[TRK_W-1]}}, min_r};

  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    if (track && (raw > signed'(max_ext))) begin
      max_nxt = raw[TRK_W-1:0];
    end
    if (track && (raw < signed'(min_ext))) begin
      min_nxt = raw[TRK_W-1:0];
    end
  end

  // Halving rounds toward zero: a negative sum is bumped by one before the arithmetic shift.
  assign sum        = {max_nxt[TRK_W-1], max_nxt} + {min_nxt[TRK_W-1], min_nxt};
  assign rnd        = sum + {{TRK_W{1'b0}}, sum[TRK_W]};
  assign offset_nxt = complete ? rnd[TRK_W:1] : offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= MAX_RST;
      min_r    <= MIN_RST;
      offset_r <= OFFSET_RST;
    end else begin
      max_r    <= max_nxt;
      min_r    <= min_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corr_r <= raw_ext - {{(CORR_W-TRK_W){offset_r[TRK_W-1]}}, offset_r};
    end
  end

  assign stat.in_gate = {{(RAW_W+1-GATE_W){1'b0}}, gate_limit} > mag;
  assign stat.range   = {max_r[TRK_W-1], max_r} - {min_r[TRK_W-1], min_r};
  assign corrected    = corr_r;
  assign offset       = offset_r;

endmodule

[hdl/mmoc_div.sv]
// Restoring divider for the gain ratio, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps

module mmoc_div
  import mmoc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RANGE_W-1:0] num,
  input  logic [RANGE_W-1:0] den,
  output div_res_t           res
);

  logic                 busy_r, done_r;
  logic [RANGE_W-1:0]   rem_r, den_r;
  logic [GAIN_Q_W-1:0]  low_r, q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DW-1:0]    dvd;
  logic [RANGE_W-1:0]   rem0;
  logic [RANGE_W:0]     trial, diff;
  logic                 ge;

  // The upper dividend bits alone decide whether the quotient fits its width.
  assign dvd   = {num, {GAIN_FRAC_BITS{1'b0}}};
  assign rem0  = RANGE_W'(dvd[DIV_DW-1:GAIN_Q_W]);
  assign trial = {rem_r, low_r[GAIN_Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (rem0 >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && (cnt_r == DIV_CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      den_r <= den;
      low_r <= dvd[GAIN_Q_W-1:0];
      cnt_r <= DIV_CNT_W'(GAIN_Q_W);
      q_r   <= (rem0 >= den) ? {GAIN_Q_W{1'b1}} : {GAIN_Q_W{1'b0}};
    end else if (busy_r) begin
      rem_r <= ge ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
      low_r <= {low_r[GAIN_Q_W-2:0], 1'b0};
      q_r   <= {q_r[GAIN_Q_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign res.done = done_r;
  assign res.quot = {1'b0, q_r};

endmodule

[hdl/mag_min_max_offset_calibration.sv]
// Top level of the magnetometer hard-iron calibration: axis lanes, merge logic and gain divider.
`timescale 1ns / 1ps

// Each transfer carries one X/Y/Z sample and yields one result transfer holding the sample
// minus the offset in force before it, plus the offsets, gains and calibration status after
// it. The result of an ordinary sample appears in the cycle after it is taken, and a new
// sample is taken at the same edge at which the previous result is transferred. The sample
// that completes calibration holds the input while the Y and Z gains are computed one after
// the other in a shared restoring divider that produces one quotient bit per cycle.
// Configuration is written through a simple write port and takes effect on the next sample.

module mag_min_max_offset_calibration
  import mmoc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [RAW_W-1:0]   in_raw_x,
  input  logic signed [RAW_W-1:0]   in_raw_y,
  input  logic signed [RAW_W-1:0]   in_raw_z,
  input  logic                      in_start_calibration,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [CORR_W-1:0]  out_corrected_x,
  output logic signed [CORR_W-1:0]  out_corrected_y,
  output logic signed [CORR_W-1:0]  out_corrected_z,
  output logic signed [TRK_W-1:0]   out_offset_x_out,
  output logic signed [TRK_W-1:0]   out_offset_y_out,
  output logic signed [TRK_W-1:0]   out_offset_z_out,
  output logic signed [GAIN_W-1:0]  out_gain_y_out,
  output logic signed [GAIN_W-1:0]  out_gain_z_out,
  output logic                      out_calibrating,
  output logic                      out_calibration_done
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    target_r, target_nxt;
  logic [GATE_W-1:0]   gate_r, gate_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt, count_base;
  logic                active_r, active_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                go_r, go_nxt;
  logic                sel_z_r, sel_z_nxt;
  logic [GAIN_W-1:0]   gain_y_r, gain_y_nxt, gain_z_r, gain_z_nxt;
  logic                accept, active_eff, gate_all, track, complete;
  lane_stat_t          stat_x, stat_y, stat_z;
  div_res_t            div_res;
  logic [RANGE_W-1:0]  div_den;

  assign in_stall   = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign active_eff = active_r || in_start_calibration;
  assign gate_all   = stat_x.in_gate && stat_y.in_gate && stat_z.in_gate;
  assign track      = accept && active_eff && gate_all;
  assign complete   = track && (count_r >= target_r);
  assign div_den    = sel_z_r ? stat_z.range : stat_y.range;

  mmoc_lane u_lane_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw        (in_raw_x),
    .gate_limit (gate_r),
    .accept     (accept),
    .track      (track),
    .complete   (complete),
    .corrected  (out_corrected_x),
    .offset     (out_offset_x_out),
    .stat       (stat_x)
  );

  mmoc_lane u_lane_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw        (in_raw_y),
    .gate_limit (gate_r),
    .accept     (accept),
    .track      (track),
    .complete   (complete),
    .corrected  (out_corrected_y),
    .offset     (out_offset_y_out),
    .stat       (stat_y)
  );

  mmoc_lane u_lane_z (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw        (in_raw_z),
    .gate_limit (gate_r),
    .accept     (accept),
    .track      (track),
    .complete   (complete),
    .corrected  (out_corrected_z),
    .offset     (out_offset_z_out),
    .stat       (stat_z)
  );

  mmoc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .num   (stat_x.range),
    .den   (div_den),
    .res   (div_res)
  );

  always_comb begin
    target_nxt    = target_r;
    gate_nxt      = gate_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    go_nxt        = 1'b0;
    sel_z_nxt     = sel_z_r;
    gain_y_nxt    = gain_y_r;
    gain_z_nxt    = gain_z_r;
    state_nxt     = state_r;
    count_base    = complete ? {CNT_W{1'b0}} : count_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET: target_nxt = cfg_data[CNT_W-1:0];
        CFG_GATE:   gate_nxt   = cfg_data[GATE_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          done_nxt   = complete;
          active_nxt = active_eff && !complete;
          if (active_eff) begin
            count_nxt = (count_base != CNT_MAX) ? count_base + 1'b1 : count_base;
          end
          if (complete) begin
            state_nxt = ST_DIV;
            go_nxt    = 1'b1;
            sel_z_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (!sel_z_r) begin
            if (div_den != '0) begin
              gain_y_nxt = div_res.quot;
            end
            sel_z_nxt = 1'b1;
            go_nxt    = 1'b1;
          end else begin
            if (div_den != '0) begin
              gain_z_nxt = div_res.quot;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= TARGET_RST;
      gate_r      <= GATE_RST;
      count_r     <= '0;
      active_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
      sel_z_r     <= 1'b0;
      gain_y_r    <= GAIN_Y_RST;
      gain_z_r    <= GAIN_Z_RST;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      gate_r      <= gate_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      go_r        <= go_nxt;
      sel_z_r     <= sel_z_nxt;
      gain_y_r    <= gain_y_nxt;
      gain_z_r    <= gain_z_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_gain_y_out       = gain_y_r;
  assign out_gain_z_out       = gain_z_r;
  assign out_calibrating      = active_r;
  assign out_calibration_done = done_r;

  a_done_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> !active_r)
    else $error("completion reported while calibration still active");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the gain phase");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || (state_r == ST_DIV)))
    else $error("accepted transfer produced neither a result nor a gain phase");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (count_r != '0))
    else $error("calibration active with an empty sample count");

endmodule
